[rtl/core/rpa_pkg.sv]
// Shared types and constants for the reference-counted page allocator.
`timescale 1ns / 1ps

package rpa_pkg;

   localparam int PAGES_DEFAULT = 4096;
   localparam int PAGE_W        = 12;
   localparam int OP_W          = 3;
   localparam int STATUS_W      = 3;
   localparam int COUNT_W       = 8;
   localparam int REQ_DATA_W    = 16;
   localparam int RSP_DATA_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

   typedef enum logic [OP_W-1:0] {
      OP_USABLE   = 3'd0,
      OP_RESERVED = 3'd1,
      OP_FINISH   = 3'd2,
      OP_ALLOC    = 3'd3,
      OP_REF      = 3'd4,
      OP_UNREF    = 3'd5,
      OP_RESERVE  = 3'd6,
      OP_NOP      = 3'd7
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOMEM    = 3'd1,
      ST_BADREF   = 3'd2,
      ST_UNDERREF = 3'd3,
      ST_RESWARN  = 3'd4
   } status_type;

   // One page-table entry as stored in the RAM.
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               usable;
      logic               reserved;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

[rtl/core/rpa_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module rpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

[rtl/core/refcounted_page_allocator_top.sv]
// Reference-counted physical page allocator: page table RAM and its sequencer.
//
// Requests arrive on the req_ channel: req_tuser carries the operation and
// req_tdata the page number. Every request yields exactly one response on the
// rsp_ channel with the page and a status code.
// The page table (count, usable bit, reserved bit per page) lives in one RAM
// with a registered read; the block works on one request at a time.
// Mark usable/reserved, ref, unref and reserve issue the read on acceptance,
// do the read-modify-write in S_EXEC and load the response in S_DONE; a new
// request is taken only once the block is back in S_IDLE.
// Finish and a successful alloc (unless it hands out the last page) scan the
// table upward one entry per cycle through the RAM read port; the scan stops
// at the first matching page.
// After reset the block sweeps the RAM to zero, one entry per cycle, and
// req_tready stays low until the sweep ends.
// A response is held in an output register until rsp_tready takes it. The
// next request is accepted meanwhile; its response waits behind the held one.
`timescale 1ns / 1ps

module refcounted_page_allocator_top #(
   parameter int PAGES = rpa_pkg::PAGES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rpa_pkg::REQ_DATA_W-1:0]  req_tdata,  // [11:0] page
   input  logic [rpa_pkg::OP_W-1:0]        req_tuser,  // [2:0] op
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rpa_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [11:0] result_page, [14:12] status
);

   import rpa_pkg::*;

   localparam int AW = $clog2(PAGES);
   localparam logic [AW-1:0] LAST = AW'(PAGES - 1);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DONE
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic                  inr_ff, inr_in;
   logic [AW-1:0]         first_free_ff, first_free_in;
   logic [AW-1:0]         scan_addr_ff, scan_addr_in;
   logic                  scan_live_ff, scan_live_in;
   logic                  chk_valid_ff, chk_valid_in;
   logic [AW-1:0]         chk_addr_ff, chk_addr_in;
   status_type            status_ff, status_in;
   logic [PAGE_W-1:0]     res_page_ff, res_page_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_fire;
   op_type                req_op;
   logic [PAGE_W-1:0]     req_page;
   logic                  req_inr;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   entry_type             ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [ENTRY_W-1:0]    ram_rdata;
   entry_type             rd;
   logic                  scan_hit;
   logic [AW-1:0]         page_addr;

   rpa_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(PAGES)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = op_type'(req_tuser);
   assign req_page   = req_tdata[PAGE_W-1:0];
   assign req_inr    = 32'(req_page) < 32'(PAGES);
   assign rd         = entry_type'(ram_rdata);
   assign page_addr  = AW'(page_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Finish looks for the lowest usable, unreserved page; alloc also wants a zero count.
   assign scan_hit = chk_valid_ff && rd.usable && !rd.reserved &&
                     (op_ff == OP_FINISH || rd.count == '0);

   always_comb begin
      case (state_ff)
         S_IDLE:  ram_raddr = (req_op == OP_ALLOC) ? first_free_ff : AW'(req_page);
         default: ram_raddr = scan_addr_ff;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      page_in       = page_ff;
      inr_in        = inr_ff;
      first_free_in = first_free_ff;
      scan_addr_in  = scan_addr_ff;
      scan_live_in  = scan_live_ff;
      chk_valid_in  = chk_valid_ff;
      chk_addr_in   = chk_addr_ff;
      status_in     = status_ff;
      res_page_in   = res_page_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_waddr     = page_addr;
      ram_wdata     = rd;

      case (state_ff)
         S_CLEAR: begin
            ram_we       = 1'b1;
            ram_waddr    = scan_addr_ff;
            ram_wdata    = '0;
            scan_addr_in = AW'(scan_addr_ff + 1'b1);
            if (scan_addr_ff == LAST) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_fire) begin
               op_in       = req_op;
               page_in     = req_page;
               inr_in      = req_inr;
               status_in   = ST_OK;
               res_page_in = req_page;
               case (req_op)
                  OP_FINISH: begin
                     state_in     = S_SCAN;
                     scan_addr_in = '0;
                     scan_live_in = 1'b1;
                     chk_valid_in = 1'b0;
                  end
                  OP_NOP:  state_in = S_DONE;
                  default: state_in = S_EXEC;
               endcase
            end
         end

         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff)
               OP_USABLE: begin
                  ram_we           = inr_ff;
                  ram_wdata.usable = 1'b1;
               end
               OP_RESERVED: begin
                  ram_we             = inr_ff;
                  ram_wdata.reserved = 1'b1;
               end
               OP_ALLOC: begin
                  res_page_in = PAGE_W'(first_free_ff);
                  if (rd.count != '0) begin
                     status_in = ST_NOMEM;
                  end else begin
                     ram_we          = 1'b1;
                     ram_waddr       = first_free_ff;
                     ram_wdata.count = COUNT_W'(1);
                     // The handed-out page now has a count of one, so the
                     // search for the next free page starts just above it.
                     if (first_free_ff != LAST) begin
                        state_in     = S_SCAN;
                        scan_addr_in = AW'(first_free_ff + 1'b1);
                        scan_live_in = 1'b1;
                        chk_valid_in = 1'b0;
                     end
                  end
               end
               OP_REF: begin
                  if (!inr_ff || rd.count == '0 || rd.count == COUNT_MAX) begin
                     status_in = ST_BADREF;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.count = COUNT_W'(rd.count + 1'b1);
                  end
               end
               OP_UNREF: begin
                  if (!inr_ff || rd.count == '0) begin
                     status_in = ST_UNDERREF;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.count = COUNT_W'(rd.count - 1'b1);
                     if (rd.count == COUNT_W'(1) && first_free_ff > page_addr &&
                         rd.usable && !rd.reserved) begin
                        first_free_in = page_addr;
                     end
                  end
               end
               OP_RESERVE: begin
                  if (!inr_ff) begin
                     status_in = ST_RESWARN;
                  end else begin
                     ram_we          = 1'b1;
                     ram_wdata.count = COUNT_W'(rd.count + 1'b1);
                     if (rd.count != '0 || (rd.usable && !rd.reserved)) begin
                        status_in = ST_RESWARN;
                     end
                  end
               end
               default: ;
            endcase
         end

         S_SCAN: begin
            // One read is issued per cycle; its data is checked in the next cycle.
            if (scan_live_ff) begin
               scan_addr_in = AW'(scan_addr_ff + 1'b1);
               scan_live_in = (scan_addr_ff != LAST);
               chk_addr_in  = scan_addr_ff;
            end
            chk_valid_in = scan_live_ff;
            if (scan_hit) begin
               first_free_in = chk_addr_ff;
               scan_live_in  = 1'b0;
               chk_valid_in  = 1'b0;
               state_in      = S_DONE;
            end else if (chk_valid_ff && !scan_live_ff) begin
               chk_valid_in = 1'b0;
               state_in     = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({status_ff, res_page_ff});
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         first_free_ff <= '0;
         scan_addr_ff  <= '0;
         scan_live_ff  <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_free_ff <= first_free_in;
         scan_addr_ff  <= scan_addr_in;
         scan_live_ff  <= scan_live_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff       <= op_in;
      page_ff     <= page_in;
      inr_ff      <= inr_in;
      chk_addr_ff <= chk_addr_in;
      status_ff   <= status_in;
      res_page_ff <= res_page_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[bench/refcounted_page_allocator_top_test.sv]
// Self-checking bench for the page allocator: stream driver, response monitor, page-table model.
`timescale 1ns / 1ps

module refcounted_page_allocator_top_test;
   import rpa_pkg::*;

   localparam int PAGES      = PAGES_DEFAULT;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      op_type            op;
      logic [PAGE_W-1:0] page;
      bit                drain;  // hold this request until every response is back
   } page_req_type;

   typedef struct {
      logic [PAGE_W-1:0] page;
      status_type        status;
   } page_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // [11:0] page
   logic [OP_W-1:0]       req_tuser = '0;  // [2:0] op
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // [11:0] result_page, [14:12] status

   page_req_type page_req_q[$];
   page_rsp_type page_rsp_q[$];

   // Shadow page table.
   bit [COUNT_W-1:0] count_tbl [PAGES];
   bit               usable_tbl [PAGES];
   bit               resv_tbl [PAGES];
   logic [PAGE_W-1:0] first_free = '0;

   int   mismatches = 0;
   int   idle_cycles = 0;
   int   burst_left = 0;
   int   gap_left = 0;
   logic [7:0] stall_phase = '0;

   refcounted_page_allocator_top #(.PAGES(PAGES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic bit page_free(int p);
      return usable_tbl[p] && !resv_tbl[p];
   endfunction

   // Applies one request to the shadow table and queues the response it owes.
   function automatic void step_page_table(op_type op, logic [PAGE_W-1:0] pg);
      page_rsp_type r;
      int           i;
      bit           found;
      r.page   = pg;
      r.status = ST_OK;
      found    = 1'b0;
      case (op)
         OP_USABLE:   usable_tbl[pg] = 1'b1;
         OP_RESERVED: resv_tbl[pg] = 1'b1;
         OP_FINISH: begin
            for (i = 0; i < PAGES && !found; i++) begin
               if (page_free(i)) begin
                  first_free = i[PAGE_W-1:0];
                  found = 1'b1;
               end
            end
         end
         OP_ALLOC: begin
            r.page = first_free;
            if (count_tbl[first_free] != 0) begin
               r.status = ST_NOMEM;
            end else begin
               count_tbl[first_free] = 1;
               for (i = int'(first_free); i < PAGES && !found; i++) begin
                  if (count_tbl[i] == 0 && page_free(i)) begin
                     first_free = i[PAGE_W-1:0];
                     found = 1'b1;
                  end
               end
            end
         end
         OP_REF: begin
            if (count_tbl[pg] == 0 || count_tbl[pg] == COUNT_MAX) r.status = ST_BADREF;
            else count_tbl[pg] = count_tbl[pg] + 1'b1;
         end
         OP_UNREF: begin
            if (count_tbl[pg] == 0) begin
               r.status = ST_UNDERREF;
            end else begin
               count_tbl[pg] = count_tbl[pg] - 1'b1;
               if (count_tbl[pg] == 0 && first_free > pg && page_free(int'(pg)))
                  first_free = pg;
            end
         end
         OP_RESERVE: begin
            // The count wraps from its maximum back to zero.
            count_tbl[pg] = count_tbl[pg] + 1'b1;
            if (count_tbl[pg] != 1 || page_free(int'(pg))) r.status = ST_RESWARN;
         end
         default: ;
      endcase
      page_rsp_q.push_back(r);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic add_req(op_type op, int pg, bit drain = 1'b0);
      page_req_type q;
      q.op    = op;
      q.page  = pg[PAGE_W-1:0];
      q.drain = drain;
      page_req_q.push_back(q);
   endtask

   // Most traffic stays in a small window so that allocations, refs and unrefs meet.
   function automatic int random_page();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 63);
      else if (r < 90) return $urandom_range(64, 511);
      return $urandom_range(0, PAGES - 1);
   endfunction

   task automatic add_random_reqs(int n, bit drain_first);
      int     k;
      int     r;
      op_type op;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         if (r < 20) op = OP_USABLE;
         else if (r < 25) op = OP_RESERVED;
         else if (r < 29) op = OP_FINISH;
         else if (r < 52) op = OP_ALLOC;
         else if (r < 65) op = OP_REF;
         else if (r < 86) op = OP_UNREF;
         else if (r < 96) op = OP_RESERVE;
         else op = OP_NOP;
         add_req(op, random_page(), drain_first && k == 0);
      end
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin : drive_req
      page_req_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) step_page_table(op_type'(req_tuser), req_tdata[PAGE_W-1:0]);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (page_req_q.size() == 0 ||
                         (page_req_q[0].drain && page_rsp_q.size() != 0)) begin
               req_tvalid <= 1'b0;
            end else begin
               item = page_req_q.pop_front();
               req_tuser  <= item.op;
               req_tdata  <= {{(REQ_DATA_W - PAGE_W){1'b0}}, item.page};
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 24);
                  gap_left   <= ($urandom_range(0, 99) < 40) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end
         end
      end
   end

   // Response backpressure cycles through full speed, alternate, random and sparse.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         stall_phase <= '0;
      end else begin
         stall_phase <= stall_phase + 1'b1;
         case (stall_phase[7:6])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= stall_phase[0];
            2'd2: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= (stall_phase[2:0] == 3'd0);
         endcase
      end
   end

   always @(posedge clock) begin : check_rsp
      page_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (page_rsp_q.size() == 0) begin
            report_mismatch("unrequested response", int'(rsp_tdata), 0);
         end else begin
            want = page_rsp_q.pop_front();
            if (rsp_tdata[PAGE_W-1:0] != want.page)
               report_mismatch("result_page", int'(rsp_tdata[PAGE_W-1:0]), int'(want.page));
            if (rsp_tdata[PAGE_W+STATUS_W-1:PAGE_W] != want.status)
               report_mismatch("status", int'(rsp_tdata[PAGE_W+STATUS_W-1:PAGE_W]),
                               int'(want.status));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int k;

      // Finish before any page is usable leaves first-free alone; alloc then
      // hands out page 0 without checking its usable bit.
      add_req(OP_FINISH, 12'hABC);
      add_req(OP_ALLOC, 12'hFFF);
      add_req(OP_ALLOC, 0);
      add_req(OP_REF, 12'hFFF);
      add_req(OP_UNREF, 12'hFFF);
      add_req(OP_USABLE, 12'hFFF);
      add_req(OP_USABLE, 3);
      add_req(OP_USABLE, 5);
      add_req(OP_USABLE, 12'h800);
      add_req(OP_RESERVED, 3);
      add_req(OP_FINISH, 0);
      // Walk the table to its top, then fail once nothing free is left.
      add_req(OP_ALLOC, 0);
      add_req(OP_ALLOC, 0);
      add_req(OP_ALLOC, 0);
      add_req(OP_ALLOC, 0);
      add_req(OP_REF, 5);
      add_req(OP_UNREF, 5);
      add_req(OP_UNREF, 5);
      add_req(OP_UNREF, 5);
      add_req(OP_RESERVE, 3);
      add_req(OP_RESERVE, 3);
      add_req(OP_RESERVE, 7);
      add_req(OP_RESERVE, 12'h800);
      add_req(OP_NOP, 12'hFFF);
      add_req(OP_REF, 0);

      add_random_reqs(360, 1'b1);

      // Drive one page's count into saturation, then wrap it through reserve.
      add_req(OP_RESERVE, 100, 1'b1);
      for (k = 0; k < 256; k++) add_req(OP_REF, 100);
      add_req(OP_RESERVE, 100);
      add_req(OP_RESERVE, 100);
      add_req(OP_RESERVE, 100);
      add_req(OP_UNREF, 100);

      add_random_reqs(360, 1'b1);
      add_random_reqs(360, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Sampled mid-cycle so that the driver's updates of the edge are settled.
      while (page_req_q.size() != 0 || req_tvalid || page_rsp_q.size() != 0) @(negedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
